// File: sv/fixed_block_pool_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Shorthand for clocked checks on clk with rst_n as the disable.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH

// cond must hold at every clock edge out of reset
`define FBPA_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// cond must hold in the cycle after trig
`define FBPA_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: sv/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Field widths, status and action codes, request and response types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

    localparam int CNT_W = 11;
    localparam int IDX_W = 10;
    localparam int ST_W  = 2;

    localparam logic [CNT_W-1:0] TOTAL_RESET = 11'd1024;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_OOM     = 2'd1;
    localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_ALLOC,
        S_READ
    } fbpa_state_t;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] block_index;
    } fbpa_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] allocated_count;
        logic [IDX_W-1:0] high_mark;
    } fbpa_rsp_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } fbpa_ram_ctl_t;

endpackage

`default_nettype wire

// File: sv/fbpa_link_ram.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator link RAM
// Single-port synchronous RAM for the free-list links, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbpa_link_ram
    import fbpa_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire fbpa_ram_ctl_t    ctl,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [CNT_W-1:0] wdata,
    output logic      [CNT_W-1:0] rdata
);

    logic [CNT_W-1:0] link_mem [DEPTH];
    logic [CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            link_mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= link_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Free: response registered in the cycle after the request is accepted.
// Alloc: the link RAM read is issued on accept and the response registered in S_READ;
// a chunk set-up of n blocks first adds n link writes, one per cycle on the single RAM port, then a head check.
// Reset and every total_blocks write start a set-up pass that writes
// min(CHUNK_BLOCKS, pool size) links; requests stall until it ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_block_pool_allocator_top_macros.svh"

module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS   = 1024,
    parameter int CHUNK_BLOCKS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire fbpa_req_t        req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output fbpa_rsp_t             rsp,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    localparam int AW         = $clog2(MAX_BLOCKS);
    localparam int POOL_RESET = (int'(TOTAL_RESET) > MAX_BLOCKS) ? MAX_BLOCKS
                                                                 : int'(TOTAL_RESET);
    localparam int INIT_RESET = (CHUNK_BLOCKS < POOL_RESET) ? CHUNK_BLOCKS : POOL_RESET;
    localparam logic [CNT_W-1:0] INIT_RESET_V = CNT_W'(INIT_RESET);
    localparam logic [CNT_W-1:0] CHUNK_V      = CNT_W'(CHUNK_BLOCKS);

    function automatic logic [CNT_W-1:0] clamp_pool(input logic [CNT_W-1:0] t);
        logic [CNT_W-1:0] p;
        p = t;
        if (t == '0)
        begin
            p = CNT_W'(1);
        end
        else if (32'(t) > MAX_BLOCKS)
        begin
            p = CNT_W'(MAX_BLOCKS);
        end
        return p;
    endfunction

    fbpa_state_t      state_reg, state_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] alloc_reg, alloc_next;
    logic [CNT_W-1:0] init_reg, init_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [IDX_W-1:0] high_reg, high_next;
    logic [CNT_W-1:0] sweep_idx_reg, sweep_idx_next;
    logic [CNT_W-1:0] sweep_end_reg, sweep_end_next;
    logic             sweep_alloc_reg, sweep_alloc_next;
    logic             rsp_valid_reg, rsp_valid_next;
    fbpa_rsp_t        rsp_reg;

    fbpa_rsp_t        rsp_fill;
    logic             rsp_load;
    logic             slot_free;
    logic [CNT_W-1:0] pool;
    logic [CNT_W-1:0] cfg_pool;
    logic [CNT_W-1:0] chunk_rem;
    logic [CNT_W-1:0] chunk_n;
    logic [CNT_W-1:0] cfg_n;
    logic [IDX_W-1:0] granted;
    logic [CNT_W:0]   live_sum;

    fbpa_ram_ctl_t    ram_ctl;
    logic [AW-1:0]    ram_addr;
    logic [CNT_W-1:0] ram_wdata;
    logic [CNT_W-1:0] ram_rdata;

    fbpa_link_ram #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_link_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign pool      = clamp_pool(total_reg);
    assign cfg_pool  = clamp_pool(cfg_data);
    assign chunk_rem = pool - init_reg;
    assign chunk_n   = (chunk_rem > CHUNK_V) ? CHUNK_V : chunk_rem;
    assign cfg_n     = (cfg_pool > CHUNK_V) ? CHUNK_V : cfg_pool;
    assign granted   = IDX_W'(head_reg);
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    assign req_stall = !((state_reg == S_IDLE) && slot_free);
    assign cfg_ready = (state_reg == S_IDLE) || ((state_reg == S_SWEEP) && !sweep_alloc_reg);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next       = state_reg;
        total_next       = total_reg;
        head_next        = head_reg;
        alloc_next       = alloc_reg;
        init_next        = init_reg;
        free_next        = free_reg;
        high_next        = high_reg;
        sweep_idx_next   = sweep_idx_reg;
        sweep_end_next   = sweep_end_reg;
        sweep_alloc_next = sweep_alloc_reg;
        ram_ctl          = '0;
        ram_addr         = '0;
        ram_wdata        = '0;
        rsp_load         = 1'b0;
        rsp_fill.granted_index   = '0;
        rsp_fill.status          = ST_OK;
        rsp_fill.free_count      = free_reg;
        rsp_fill.allocated_count = alloc_reg;
        rsp_fill.high_mark       = high_reg;

        case (state_reg)
            S_SWEEP:
            begin
                ram_ctl.wr     = 1'b1;
                ram_addr       = AW'(sweep_idx_reg);
                ram_wdata      = CNT_W'(sweep_idx_reg + 1'b1);
                sweep_idx_next = CNT_W'(sweep_idx_reg + 1'b1);
                if (CNT_W'(sweep_idx_reg + 1'b1) == sweep_end_reg)
                begin
                    state_next = sweep_alloc_reg ? S_ALLOC : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid && slot_free)
                begin
                    case (req.action)
                        ACT_FREE:
                        begin
                            rsp_load = 1'b1;
                            if ((alloc_reg == '0) || (CNT_W'(req.block_index) >= pool))
                            begin
                                rsp_fill.status = ST_BADFREE;
                            end
                            else
                            begin
                                ram_ctl.wr   = 1'b1;
                                ram_addr     = AW'(req.block_index);
                                ram_wdata    = head_reg;
                                head_next    = CNT_W'(req.block_index);
                                alloc_next   = CNT_W'(alloc_reg - 1'b1);
                                free_next    = CNT_W'(free_reg + 1'b1);
                                rsp_fill.free_count      = CNT_W'(free_reg + 1'b1);
                                rsp_fill.allocated_count = CNT_W'(alloc_reg - 1'b1);
                            end
                        end
                        ACT_ALLOC:
                        begin
                            if (alloc_reg >= init_reg)
                            begin
                                if (init_reg >= pool)
                                begin
                                    rsp_load        = 1'b1;
                                    rsp_fill.status = ST_OOM;
                                end
                                else
                                begin
                                    init_next        = CNT_W'(init_reg + chunk_n);
                                    free_next        = CNT_W'(free_reg + chunk_n);
                                    sweep_idx_next   = init_reg;
                                    sweep_end_next   = CNT_W'(init_reg + chunk_n);
                                    sweep_alloc_next = 1'b1;
                                    state_next       = S_SWEEP;
                                end
                            end
                            else if (head_reg >= pool)
                            begin
                                rsp_load        = 1'b1;
                                rsp_fill.status = ST_OOM;
                            end
                            else
                            begin
                                ram_ctl.rd = 1'b1;
                                ram_addr   = AW'(head_reg);
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                sweep_alloc_next = 1'b0;
                if (head_reg >= pool)
                begin
                    rsp_load        = 1'b1;
                    rsp_fill.status = ST_OOM;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ram_ctl.rd = 1'b1;
                    ram_addr   = AW'(head_reg);
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                head_next  = ram_rdata;
                alloc_next = CNT_W'(alloc_reg + 1'b1);
                free_next  = CNT_W'(free_reg - 1'b1);
                if (granted > high_reg)
                begin
                    high_next = granted;
                end
                rsp_load                 = 1'b1;
                rsp_fill.granted_index   = granted;
                rsp_fill.free_count      = CNT_W'(free_reg - 1'b1);
                rsp_fill.allocated_count = CNT_W'(alloc_reg + 1'b1);
                rsp_fill.high_mark       = (granted > high_reg) ? granted : high_reg;
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // pool re-setup on register write
        if (cfg_valid && cfg_ready)
        begin
            total_next       = cfg_data;
            head_next        = '0;
            alloc_next       = '0;
            high_next        = '0;
            init_next        = cfg_n;
            free_next        = cfg_n;
            sweep_idx_next   = '0;
            sweep_end_next   = cfg_n;
            sweep_alloc_next = 1'b0;
            state_next       = S_SWEEP;
        end

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            total_reg       <= TOTAL_RESET;
            head_reg        <= '0;
            alloc_reg       <= '0;
            init_reg        <= INIT_RESET_V;
            free_reg        <= INIT_RESET_V;
            high_reg        <= '0;
            sweep_idx_reg   <= '0;
            sweep_end_reg   <= INIT_RESET_V;
            sweep_alloc_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            total_reg       <= total_next;
            head_reg        <= head_next;
            alloc_reg       <= alloc_next;
            init_reg        <= init_next;
            free_reg        <= free_next;
            high_reg        <= high_next;
            sweep_idx_reg   <= sweep_idx_next;
            sweep_end_reg   <= sweep_end_next;
            sweep_alloc_reg <= sweep_alloc_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_fill;
        end
    end

    assign live_sum = (CNT_W+1)'(free_reg) + (CNT_W+1)'(alloc_reg);

    `FBPA_ASSERT_HOLDS(a_count_balance, live_sum == (CNT_W+1)'(init_reg), "free plus allocated differs from set-up count")
    `FBPA_ASSERT_HOLDS(a_init_in_pool, init_reg <= pool, "set-up count beyond pool size")
    `FBPA_ASSERT_HOLDS(a_ram_one_access, !(ram_ctl.wr && ram_ctl.rd), "link RAM read and write in one cycle")
    `FBPA_ASSERT_NEXT(a_read_delivers, state_reg == S_READ, rsp_valid_reg, "link read did not produce a response")

endmodule

`default_nettype wire

// File: tb/sv/fixed_block_pool_allocator_top_test.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives directed and random alloc/free requests and several pool sizes.
// A local pool model predicts every response, which is checked in order.
// Both handshakes idle and stall at random, with one long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_block_pool_allocator_top_test;
    import fbpa_pkg::*;

    localparam int MAX_BLOCKS   = 1024;
    localparam int GEN          = 0;
    localparam int CHK          = 1;
    localparam int RANDOM_STOP  = 1225;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_LEN     = 300;
    localparam int LIMIT_CYCLES = 600000;

    localparam logic [CNT_W-1:0] POOL_MAX = 11'd1024;
    localparam logic [CNT_W-1:0] CHUNK_N  = 11'd16;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    fbpa_req_t        req = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    fbpa_rsp_t        rsp;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    // Two copies of the pool: one runs ahead with the request generator,
    // the other follows accepted requests and predicts responses.
    logic [CNT_W-1:0] chain_link [2][MAX_BLOCKS];
    bit               link_set   [2][MAX_BLOCKS];
    logic [CNT_W-1:0] pool_n     [2];
    logic [CNT_W-1:0] head_blk   [2];
    logic [CNT_W-1:0] n_alloc    [2];
    logic [CNT_W-1:0] n_init     [2];
    logic [CNT_W-1:0] n_free     [2];
    logic [IDX_W-1:0] top_grant  [2];

    fbpa_req_t        req_backlog [$];
    fbpa_rsp_t        due_rsps [$];
    logic [IDX_W-1:0] held_blocks [$];
    logic [IDX_W-1:0] last_freed = '0;
    bit               has_last = 1'b0;

    int  items_offered = 0;
    int  rsp_count = 0;
    int  mismatches = 0;
    bit  req_fire = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    fixed_block_pool_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void add_chunk(input int c);
        logic [CNT_W-1:0] span;
        logic [CNT_W-1:0] k;
        logic [CNT_W-1:0] blk;
        span = pool_n[c] - n_init[c];
        if (span > CHUNK_N)
            span = CHUNK_N;
        for (k = '0; k < span; k = k + 1'b1)
        begin
            blk = n_init[c] + k;
            chain_link[c][blk[IDX_W-1:0]] = blk + 1'b1;
            link_set[c][blk[IDX_W-1:0]] = 1'b1;
        end
        n_init[c] = n_init[c] + span;
        n_free[c] = n_free[c] + span;
    endfunction

    // Links survive a resize; only the first chunk is laid down again.
    function automatic void pool_restart(input int c, input logic [CNT_W-1:0] total);
        if (total == '0)
            pool_n[c] = 11'd1;
        else if (total > POOL_MAX)
            pool_n[c] = POOL_MAX;
        else
            pool_n[c] = total;
        n_init[c] = '0;
        n_free[c] = '0;
        add_chunk(c);
        head_blk[c] = '0;
        n_alloc[c] = '0;
        top_grant[c] = '0;
    endfunction

    // True when an alloc would follow a link that was never written.
    function automatic bit alloc_hits_unset(input int c);
        logic [CNT_W-1:0] init_after;
        logic [CNT_W-1:0] h;
        init_after = n_init[c];
        h = head_blk[c];
        if (n_alloc[c] >= n_init[c])
        begin
            if (n_init[c] >= pool_n[c])
                return 1'b0;
            init_after = (pool_n[c] - n_init[c] > CHUNK_N) ? n_init[c] + CHUNK_N : pool_n[c];
        end
        if (h >= pool_n[c] || n_alloc[c] >= init_after)
            return 1'b0;
        return !(link_set[c][h[IDX_W-1:0]] || (h >= n_init[c] && h < init_after));
    endfunction

    function automatic fbpa_rsp_t pool_respond(input int c, input fbpa_req_t r);
        fbpa_rsp_t        o;
        logic [CNT_W-1:0] slot;
        o = '0;
        o.status = ST_OK;
        slot = {1'b0, r.block_index};
        if (r.action == ACT_ALLOC)
        begin
            if (n_alloc[c] >= n_init[c])
            begin
                if (n_init[c] >= pool_n[c])
                    o.status = ST_OOM;
                else
                    add_chunk(c);
            end
            if (o.status == ST_OK)
            begin
                if (head_blk[c] >= pool_n[c] || n_alloc[c] >= n_init[c])
                    o.status = ST_OOM;
                else
                begin
                    o.granted_index = head_blk[c][IDX_W-1:0];
                    head_blk[c] = chain_link[c][head_blk[c][IDX_W-1:0]];
                    if (o.granted_index > top_grant[c])
                        top_grant[c] = o.granted_index;
                    n_alloc[c] = n_alloc[c] + 1'b1;
                    n_free[c] = n_free[c] - 1'b1;
                end
            end
        end
        else if (n_alloc[c] == '0 || slot >= pool_n[c])
            o.status = ST_BADFREE;
        else
        begin
            chain_link[c][r.block_index] = head_blk[c];
            link_set[c][r.block_index] = 1'b1;
            head_blk[c] = slot;
            n_alloc[c] = n_alloc[c] - 1'b1;
            n_free[c] = n_free[c] + 1'b1;
        end
        o.free_count = n_free[c];
        o.allocated_count = n_alloc[c];
        o.high_mark = top_grant[c];
        return o;
    endfunction

    task automatic offer(input logic act, input logic [IDX_W-1:0] idx);
        fbpa_req_t r;
        fbpa_rsp_t o;
        r.action = act;
        r.block_index = idx;
        if (act == ACT_ALLOC && alloc_hits_unset(GEN))
        begin
            r.action = ACT_FREE;
            r.block_index = IDX_W'($urandom_range(0, pool_n[GEN] - 1'b1));
        end
        o = pool_respond(GEN, r);
        if (o.status == ST_OK)
        begin
            if (r.action == ACT_ALLOC)
                held_blocks.push_back(o.granted_index);
            else
            begin
                last_freed = r.block_index;
                has_last = 1'b1;
            end
        end
        req_backlog.push_back(r);
        items_offered++;
    endtask

    task automatic offer_random();
        int unsigned      pick;
        int               k;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            offer(ACT_ALLOC, IDX_W'($urandom()));
        else if (pick < 85 && held_blocks.size() != 0)
        begin
            k = $urandom_range(0, held_blocks.size() - 1);
            idx = held_blocks[k];
            held_blocks.delete(k);
            offer(ACT_FREE, idx);
        end
        else if (pick < 91)
            offer(ACT_FREE, IDX_W'($urandom()));
        else if (pick < 94 && has_last)
            offer(ACT_FREE, last_freed);
        else
            offer(ACT_FREE, IDX_W'($urandom_range(0, pool_n[GEN] - 1'b1)));
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || due_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_total(input logic [CNT_W-1:0] total);
        wait_drained();
        @(negedge clk);
        cfg_data <= total;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        pool_restart(GEN, total);
        pool_restart(CHK, total);
        held_blocks.delete();
        has_last = 1'b0;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // request driver: bursts with random gaps, payload held while stalled
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (req_valid && !req_fire)
        begin
        end
        else if (gap_left != 0)
        begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (req_backlog.size() != 0)
        begin
            req_valid <= 1'b1;
            req <= req_backlog[0];
            if (burst_left == 0)
            begin
                burst_left <= $urandom_range(1, 24);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            req_valid <= 1'b0;
    end

    // response stall: random modes, plus one long hold-off while requests queue up
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && rsp_count >= HOLD_AT && req_backlog.size() > 20)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(10, 80);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge clk)
    begin : monitor
        fbpa_rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                due_rsps.push_back(pool_respond(CHK, req));
                void'(req_backlog.pop_front());
            end
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count++;
                if (due_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response %0d with no request pending", rsp_count);
                end
                else
                begin
                    want = due_rsps.pop_front();
                    if (rsp.granted_index !== want.granted_index
                        || rsp.status !== want.status
                        || rsp.free_count !== want.free_count
                        || rsp.allocated_count !== want.allocated_count
                        || rsp.high_mark !== want.high_mark)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response %0d: want idx=%0d st=%0d free=%0d alloc=%0d hi=%0d, got idx=%0d st=%0d free=%0d alloc=%0d hi=%0d",
                                     rsp_count, want.granted_index, want.status,
                                     want.free_count, want.allocated_count, want.high_mark,
                                     rsp.granted_index, rsp.status, rsp.free_count,
                                     rsp.allocated_count, rsp.high_mark);
                    end
                end
            end
        end
        req_fire <= rst_n && req_valid && !req_stall;
    end

    initial
    begin : watchdog
        int n;
        for (n = 0; n < LIMIT_CYCLES; n++)
            @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int               phase;
        logic [CNT_W-1:0] sz;
        logic [IDX_W-1:0] victim;
        bit               broken;
        pool_restart(GEN, TOTAL_RESET);
        pool_restart(CHK, TOTAL_RESET);
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // full pool after reset: empty frees, highest index, ignored alloc index
        offer(ACT_FREE, 10'd0);
        offer(ACT_FREE, 10'h3FF);
        offer(ACT_ALLOC, 10'h3FF);
        offer(ACT_ALLOC, 10'd0);
        offer(ACT_FREE, 10'h3FF);
        offer(ACT_ALLOC, 10'd0);
        offer(ACT_ALLOC, 10'd0);
        offer(ACT_FREE, 10'd0);
        offer(ACT_FREE, 10'd1);
        offer(ACT_FREE, 10'd2);
        offer(ACT_FREE, 10'h3FF);
        offer(ACT_FREE, 10'd0);

        // zero size acts as one block
        write_total(11'd0);
        offer(ACT_ALLOC, 10'd0);
        offer(ACT_ALLOC, 10'd0);
        offer(ACT_FREE, 10'd1);
        offer(ACT_FREE, 10'd0);

        write_total(11'd2);
        offer(ACT_ALLOC, 10'd0);
        offer(ACT_ALLOC, 10'd0);
        offer(ACT_ALLOC, 10'd0);
        offer(ACT_FREE, 10'h2AA);
        offer(ACT_FREE, 10'h155);
        offer(ACT_FREE, 10'd1);
        offer(ACT_FREE, 10'd0);

        phase = 0;
        while (items_offered < RANDOM_STOP)
        begin
            broken = 1'b0;
            case (phase)
                0:
                begin
                    sz = CNT_W'($urandom_range(18, 32));
                    broken = 1'b1;
                end
                1: sz = 11'd17;
                2: sz = POOL_MAX;
                3: sz = 11'd1;
                4: sz = 11'd2047;
                default:
                    case ($urandom_range(0, 9))
                        0: sz = POOL_MAX;
                        1: sz = CNT_W'($urandom_range(1025, 2047));
                        2:
                        begin
                            sz = CNT_W'($urandom_range(18, 32));
                            broken = 1'b1;
                        end
                        3: sz = '0;
                        default: sz = CNT_W'($urandom_range(1, 64));
                    endcase
            endcase
            write_total(sz);
            // double free of a block past the first chunk: the chunk set-up
            // later relinks it and the chain runs off the pool end
            if (broken)
            begin
                victim = IDX_W'($urandom_range(17, sz - 1'b1));
                offer(ACT_ALLOC, 10'd0);
                offer(ACT_ALLOC, 10'd0);
                offer(ACT_FREE, victim);
                offer(ACT_FREE, victim);
                repeat (22) offer(ACT_ALLOC, IDX_W'($urandom()));
            end
            repeat ($urandom_range(60, 150)) offer_random();
            phase++;
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && due_rsps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: fixed_block_pool_allocator_top.f
+incdir+sv
sv/fbpa_pkg.sv
sv/fbpa_link_ram.sv
sv/fixed_block_pool_allocator_top.sv
tb/sv/fixed_block_pool_allocator_top_test.sv
